// ----- hdl/wdb3_pkg.sv -----
// Shared types, constants and filter taps for the db3 analysis block.
`default_nettype none
package wdb3_pkg;
  localparam int MaxLevelsDef = 16;
  localparam int Taps = 6;
  localparam int TapW = 3;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // take input byte into x
    logic fetch;      // unused; never asserted by the controller
    logic mac_clr;    // clear accumulators
    logic mac_en;     // accumulate one tap
    logic commit;     // shift window, bump count
    logic adv;        // x <= low result, next level
  } wdb3_cmd_t;

  typedef struct packed {
    logic fire;       // current level filters this sample
    logic next_fire;  // level above filters the low result it gets
  } wdb3_sts_t;

  // Q28 taps, oldest sample first.
  function automatic logic signed [31:0] hp_tap(input logic [TapW-1:0] k);
    logic signed [31:0] v;
    case (k)
      3'd0: v = 32'sd9455986;
      3'd1: v = 32'sd22935467;
      3'd2: v = -32'sd36241745;
      3'd3: v = -32'sd123447427;
      3'd4: v = 32'sd216598290;
      default: v = -32'sd89300572;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] lp_tap(input logic [TapW-1:0] k);
    logic signed [31:0] v;
    case (k)
      3'd0: v = 32'sd89300572;
      3'd1: v = 32'sd216598290;
      3'd2: v = 32'sd123447427;
      3'd3: v = -32'sd36241745;
      3'd4: v = -32'sd22935467;
      default: v = 32'sd9455986;
    endcase
    return v;
  endfunction

  // Round Q48 sum to Q20 (ties up) and saturate to 32 bits.
  function automatic logic signed [31:0] round_sat(input logic signed [66:0] acc);
    logic signed [66:0] s;
    logic signed [38:0] q;
    logic signed [31:0] r;
    s = acc + 67'sd134217728;
    q = s[66:28];
    if (q > 39'sd2147483647) r = 32'sh7fffffff;
    else if (q < -39'sd2147483648) r = 32'sh80000000;
    else r = q[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- hdl/wdb3_datapath.sv -----
// Datapath: per-level windows, counters and one shared dual MAC.
`default_nettype none
module wdb3_datapath import wdb3_pkg::*; #(
  parameter int MaxLevels = MaxLevelsDef,
  localparam int LvW = (MaxLevels > 1) ? $clog2(MaxLevels) : 1,
  localparam int Depth = MaxLevels * Taps,
  localparam int AdrW = $clog2(Depth)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire wdb3_cmd_t       cmd,
  input  wire logic [LvW-1:0]  lv,
  input  wire logic [TapW-1:0] tap,
  input  wire logic [7:0]      sample_byte,
  output wdb3_sts_t            sts,
  output logic signed [31:0]   hp_out
);
  logic signed [31:0] x;
  // ring buffer per level; a level reads its window only after six writes
  logic signed [31:0] win [Depth];
  logic [2:0]         head [MaxLevels];
  logic [2:0]         cnt [MaxLevels];
  logic [LvW-1:0]     lv_nx;
  logic [3:0]         slot_sum;
  logic [2:0]         slot;
  logic [AdrW-1:0]    base;
  logic [AdrW-1:0]    rd_addr;
  logic [AdrW-1:0]    wr_addr;
  logic signed [31:0] rd;
  logic signed [63:0] hp_prod, lp_prod;
  logic signed [66:0] hp_acc, lp_acc;
  logic [TapW-1:0]    tap_d;
  logic               rd_v;
  logic               prod_v;

  assign lv_nx = lv + 1'b1;
  assign sts.fire = (cnt[lv] == 3'd6);
  assign sts.next_fire = ((32'(lv) + 1) < MaxLevels) && (cnt[lv_nx] == 3'd6);

  // oldest sample sits at head
  assign slot_sum = 4'(head[lv]) + 4'(tap);
  assign slot = (slot_sum >= 4'(Taps)) ? 3'(slot_sum - 4'(Taps)) : 3'(slot_sum);
  assign base = AdrW'(lv) * AdrW'(Taps);
  assign rd_addr = base + AdrW'(slot);
  assign wr_addr = base + AdrW'(head[lv]);

  always_ff @(posedge clk) begin
    if (cmd.commit) win[wr_addr] <= x;
    rd <= win[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MaxLevels; i++) begin
        cnt[i] <= '0;
        head[i] <= '0;
      end
      rd_v <= 1'b0;
      prod_v <= 1'b0;
    end else begin
      rd_v <= cmd.mac_en;
      prod_v <= rd_v;
      if (cmd.commit) begin
        head[lv] <= (head[lv] == 3'(Taps-1)) ? 3'd0 : head[lv] + 3'd1;
        cnt[lv] <= (cnt[lv] == 3'd7) ? 3'd6 : cnt[lv] + 3'd1;
      end
    end
  end

  // read, multiply, accumulate: one registered stage each
  always_ff @(posedge clk) begin
    tap_d <= tap;
    hp_prod <= 64'(rd) * 64'(hp_tap(tap_d));
    lp_prod <= 64'(rd) * 64'(lp_tap(tap_d));
    if (cmd.load) x <= 32'(($signed({1'b0, sample_byte}) - 10'sd128)) <<< 12;
    else if (cmd.adv) x <= round_sat(lp_acc);
    if (cmd.mac_clr) begin
      hp_acc <= '0;
      lp_acc <= '0;
    end else if (prod_v) begin
      hp_acc <= hp_acc + 67'(hp_prod);
      lp_acc <= lp_acc + 67'(lp_prod);
    end
  end

  assign hp_out = round_sat(hp_acc);
endmodule
`default_nettype wire

// ----- hdl/wdb3_ctrl.sv -----
// Controller: sequences levels, taps and result hand-off.
`default_nettype none
module wdb3_ctrl import wdb3_pkg::*; #(
  parameter int MaxLevels = MaxLevelsDef,
  localparam int LvW = (MaxLevels > 1) ? $clog2(MaxLevels) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [4:0]      num_levels,
  input  wire wdb3_sts_t       sts,
  input  wire logic            out_stall,
  output logic                 out_valid,
  output logic                 out_last,
  output logic [LvW-1:0]       lv,
  output logic [TapW-1:0]      tap,
  output wdb3_cmd_t            cmd
);
  localparam logic [2:0] S_IDLE = 3'd0, S_CHK = 3'd1, S_MAC = 3'd2,
                         S_DRAIN = 3'd3, S_OUT = 3'd4, S_DRN2 = 3'd5;
  logic [2:0] state;
  logic [5:0] active;
  logic       more;

  assign active = (6'(num_levels) > 6'(MaxLevels)) ? 6'(MaxLevels) : 6'(num_levels);
  assign in_stall = (state != S_IDLE);
  // another level runs after this one when it fires
  assign more = (6'(lv) + 6'd1) < active;

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && in_valid && (active != 6'd0);
    cmd.mac_clr = (state == S_CHK);
    cmd.mac_en = (state == S_MAC);
    cmd.commit = (state == S_CHK) && !sts.fire ||
                 (state == S_OUT) && !out_stall;
    cmd.adv = (state == S_OUT) && !out_stall;
  end

  assign out_valid = (state == S_OUT);
  // cascade stops at the last active level or where the next one does not fire
  assign out_last = !more || !sts.next_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lv <= '0;
      tap <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (cmd.load) begin
          lv <= '0;
          state <= S_CHK;
        end
        S_CHK: begin
          tap <= '0;
          state <= sts.fire ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          if (tap == TapW'(Taps-1)) state <= S_DRAIN;
          else tap <= tap + 1'b1;
        end
        S_DRAIN: state <= S_DRN2;
        S_DRN2: state <= S_OUT;
        S_OUT: if (!out_stall) begin
          if (more) begin
            lv <= lv + 1'b1;
            state <= S_CHK;
          end else state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hdl/wavelet_db3_multilevel_analysis_top.sv -----
// Top level of the multi-level db3 wavelet analysis block.
// Each word taken is checked at level 0 (S_CHK); a level that fires runs the
// MAC over its taps (S_MAC), two pipeline drain states and S_OUT, then the next.
// A new word is taken only once the cascade for the last one is through; with
// num_levels = 0 words are taken but nothing is computed or output.
// Reset (rst, synchronous): counters and ring heads zero, num_levels = 16.
// Results are held in the output stage until taken; input stalls meanwhile.
`default_nettype none
module wavelet_db3_multilevel_analysis_top import wdb3_pkg::*; #(
  parameter int MaxLevels = MaxLevelsDef
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [4:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         sample_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [3:0]              level,
  output logic signed [31:0]      detail_value,
  output logic                    last_of_run
);
  localparam int LvW = (MaxLevels > 1) ? $clog2(MaxLevels) : 1;
  logic [4:0]      num_levels;
  wdb3_cmd_t       cmd;
  wdb3_sts_t       sts;
  logic [LvW-1:0]  lv;
  logic [TapW-1:0] tap;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) num_levels <= 5'd16;
    else if (cfg_we) num_levels <= cfg_data;
  end

  wdb3_ctrl #(.MaxLevels(MaxLevels)) u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .num_levels, .sts, .out_stall,
    .out_valid, .out_last(last_of_run), .lv, .tap, .cmd
  );

  wdb3_datapath #(.MaxLevels(MaxLevels)) u_dp (
    .clk, .rst, .cmd, .lv, .tap, .sample_byte, .sts, .hp_out(detail_value)
  );

  assign level = 4'(lv);

  // result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(detail_value) && $stable(level))
    else $error("result changed under stall");
  // no new word while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open during output");
  // result level stays inside the configured range
  a_lvl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (6'(lv) < 6'(num_levels)))
    else $error("level beyond setting");
endmodule
`default_nettype wire

// ----- verif/wavelet_db3_multilevel_analysis_top_test.sv -----
// Self-checking test of the multi-level db3 wavelet analysis block.
`default_nettype none
module wavelet_db3_multilevel_analysis_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wdb3_pkg::*;

  localparam int NumLevelsMax = 16;
  localparam int CycleLimit = 3000000;

  // One expected detail word.
  typedef struct {
    logic [3:0]         level;
    logic signed [31:0] detail_value;
    logic               last_of_run;
  } detail_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] sample_byte = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] level;
  logic signed [31:0] detail_value;
  logic last_of_run;

  always #1 clk = ~clk;

  wavelet_db3_multilevel_analysis_top DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .sample_byte(sample_byte),
    .out_valid(out_valid), .out_stall(out_stall), .level(level),
    .detail_value(detail_value), .last_of_run(last_of_run)
  );

  // Predictor state: own copy of windows, counters and level setting.
  logic [4:0]         pred_levels;
  logic signed [31:0] pred_window [NumLevelsMax][6];
  logic [2:0]         pred_count [NumLevelsMax];
  detail_word_t       pending_details[$];
  int                 error_count = 0;
  int                 cycle_count = 0;
  int                 rx_wait = 0;
  bit                 rx_idle_enable = 1'b1;
  bit                 tx_idle_enable = 1'b1;

  // Q28 taps, oldest sample first.
  localparam logic signed [31:0] HighTaps [6] = '{
    32'sd9455986, 32'sd22935467, -32'sd36241745,
    -32'sd123447427, 32'sd216598290, -32'sd89300572};
  localparam logic signed [31:0] LowTaps [6] = '{
    32'sd89300572, 32'sd216598290, 32'sd123447427,
    -32'sd36241745, -32'sd22935467, 32'sd9455986};

  // Round Q48 to Q20, ties toward +inf (floor of shifted sum), then clamp.
  function automatic logic signed [31:0] q20_round_clamp(input longint acc);
    longint sum;
    longint quo;
    sum = acc + (longint'(1) <<< 27);
    quo = sum >>> 28;
    if (quo > 64'sd2147483647) return 32'sh7fffffff;
    if (quo < -64'sd2147483648) return 32'sh80000000;
    return quo[31:0];
  endfunction

  function automatic void clear_filter_state();
    for (int l = 0; l < NumLevelsMax; l++) begin
      pred_count[l] = '0;
      for (int k = 0; k < 6; k++) pred_window[l][k] = '0;
    end
  endfunction

  // Push the sample through the level cascade and queue the details it makes.
  function automatic void predict_details(input logic [7:0] b);
    int active;
    int first_new;
    logic signed [31:0] x;
    logic signed [31:0] low;
    longint hs;
    longint ls;
    bit fire;
    detail_word_t w;
    active = (pred_levels > NumLevelsMax) ? NumLevelsMax : pred_levels;
    x = (32'(b) - 32'sd128) * 32'sd4096;
    first_new = pending_details.size();
    for (int l = 0; l < active; l++) begin
      fire = (pred_count[l] == 3'd6);
      low = '0;
      if (fire) begin
        hs = 0;
        ls = 0;
        for (int k = 0; k < 6; k++) begin
          hs += longint'(pred_window[l][k]) * longint'(HighTaps[k]);
          ls += longint'(pred_window[l][k]) * longint'(LowTaps[k]);
        end
        w.level = l[3:0];
        w.detail_value = q20_round_clamp(hs);
        w.last_of_run = 1'b0;
        pending_details.push_back(w);
        low = q20_round_clamp(ls);
      end
      for (int k = 0; k < 5; k++) pred_window[l][k] = pred_window[l][k+1];
      pred_window[l][5] = x;
      pred_count[l] = (pred_count[l] == 3'd7) ? 3'd6 : pred_count[l] + 3'd1;
      if (!fire) break;
      x = low;
    end
    if (pending_details.size() > first_new)
      pending_details[pending_details.size()-1].last_of_run = 1'b1;
  endfunction

  // Receiver side: random wait per word, compare each accepted word.
  always @(posedge clk) begin
    detail_word_t exp_w;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && !out_stall) begin
      if (pending_details.size() == 0) begin
        $error("unexpected detail word level=%0d value=%0d", level, detail_value);
        error_count = error_count + 1;
      end else begin
        exp_w = pending_details.pop_front();
        if (level !== exp_w.level) begin
          $error("level: expected %0d actual %0d", exp_w.level, level);
          error_count = error_count + 1;
        end
        if (detail_value !== exp_w.detail_value) begin
          $error("detail_value: expected %0d actual %0d",
                 exp_w.detail_value, detail_value);
          error_count = error_count + 1;
        end
        if (last_of_run !== exp_w.last_of_run) begin
          $error("last_of_run: expected %0d actual %0d",
                 exp_w.last_of_run, last_of_run);
          error_count = error_count + 1;
        end
      end
      // draw a random wait, counted down while a word is offered, before taking the next word
      rx_wait = rx_idle_enable ? int'($urandom_range(0, 9)) : 0;
    end else if (out_valid && rx_wait > 0) begin
      rx_wait = rx_wait - 1;
    end
    out_stall <= (rx_wait != 0);
  end

  // Send one sample word: random gap, then hold valid until accepted.
  task automatic send_sample(input logic [7:0] b);
    int gap;
    gap = tx_idle_enable ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_details(b);
  endtask

  // Wait until every expected word arrived, then let the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_details.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Register write while idle.
  task automatic set_levels(input logic [4:0] n);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    pred_levels = n;
  endtask

  // Full-scale extremes and midpoints at the reset setting of 16 levels.
  task automatic test_extremes();
    logic [7:0] pat [12] = '{8'h00, 8'hff, 8'h80, 8'h7f, 8'h81, 8'hff,
                             8'h00, 8'h00, 8'hff, 8'hff, 8'h55, 8'haa};
    foreach (pat[i]) send_sample(pat[i]);
  endtask

  // Zero levels: nothing comes out.
  task automatic test_zero_levels();
    set_levels(5'd0);
    repeat (8) send_sample(8'($urandom_range(0, 255)));
  endtask

  // Settings above the level count act as the maximum.
  task automatic test_over_max();
    set_levels(5'd31);
    repeat (5) send_sample(8'($urandom_range(0, 255)));
  endtask

  // Random content, levels swept through extremes and middles.
  task automatic test_random_levels();
    logic [4:0] settings [6] = '{5'd1, 5'd16, 5'd3, 5'd8, 5'd17, 5'd2};
    foreach (settings[s]) begin
      set_levels(settings[s]);
      // long runs of full-scale values push the deep levels toward saturation
      for (int i = 0; i < 50; i++) begin
        if (s == 1 && i < 25) send_sample(($urandom_range(0, 1) != 0) ? 8'hff : 8'h00);
        else send_sample(8'($urandom_range(0, 255)));
        if (i == 20 && s == 0) begin
          rx_idle_enable = 1'b0;
          tx_idle_enable = 1'b0;
        end
        if (i == 40 && s == 0) begin
          rx_idle_enable = 1'b1;
          tx_idle_enable = 1'b1;
        end
      end
    end
  endtask

  // Sender holds off until the output side has emptied.
  task automatic test_pause_for_drain();
    set_levels(5'd16);
    repeat (10) send_sample(8'($urandom_range(0, 255)));
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_details.size() != 0) @(posedge clk);
    repeat (10) send_sample(8'($urandom_range(0, 255)));
  endtask

  initial begin
    pred_levels = 5'd16;
    clear_filter_state();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_zero_levels();
    test_over_max();
    test_random_levels();
    test_pause_for_drain();
    drain_results();
    if (error_count == 0) begin
      $display("wavelet_db3_multilevel_analysis_top_test: clean");
    end else begin
      $display("wavelet_db3_multilevel_analysis_top_test: errors");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("wavelet_db3_multilevel_analysis_top_test: errors");
      $finish;
    end
  end
endmodule
`default_nettype wire

// ----- wavelet_db3_multilevel_analysis_top.f -----
hdl/wdb3_pkg.sv
hdl/wdb3_datapath.sv
hdl/wdb3_ctrl.sv
hdl/wavelet_db3_multilevel_analysis_top.sv
verif/wavelet_db3_multilevel_analysis_top_test.sv
